// ----- design/tsbl_pkg.sv -----
// Shared types, widths and codes for the timestamp bracket lookup block.
package tsbl_pkg;

    localparam int DEPTH       = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int TS_W        = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FRAC_CNT_W  = $clog2(FRAC_BITS);
    localparam int LOWER_W     = 10;
    localparam int UPPER_W     = 11;
    localparam int FRAC_W      = 16;
    localparam int OUT_DATA_W  = ((LOWER_W + UPPER_W + FRAC_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [TS_W-1:0]      t_ts;
    typedef logic [FRAC_BITS-1:0] t_frac;

    localparam t_cnt DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        STS_OK       = 4'd0,
        STS_FULL     = 4'd1,
        STS_ORDER    = 4'd2,
        STS_EMPTY    = 4'd3,
        STS_SINGLE   = 4'd4,
        STS_MULTIPLE = 4'd5,
        STS_BEFORE   = 4'd6,
        STS_AFTER    = 4'd7,
        STS_INTERP   = 4'd8
    } t_status;

    typedef struct packed {
        logic start;
        t_ts  num;
        t_ts  den;
    } t_div_req;

endpackage

// ----- design/tsbl_ram.sv -----
// Simple dual-port RAM, one write port, one registered read port.
module tsbl_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/tsbl_frac_div.sv -----
// Restoring divider for the interpolation fraction, one quotient bit per cycle.
module tsbl_frac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsbl_pkg::t_div_req i_req,
    output logic               o_done,
    output tsbl_pkg::t_frac    o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [tsbl_pkg::FRAC_CNT_W-1:0]   r_cnt;
    tsbl_pkg::t_ts                     r_rem;
    tsbl_pkg::t_ts                     r_den;
    tsbl_pkg::t_frac                   r_quot;

    logic [tsbl_pkg::TS_W:0] shifted;
    logic [tsbl_pkg::TS_W:0] diff;
    logic                    take;

    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        take    = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tsbl_pkg::FRAC_CNT_W'(tsbl_pkg::FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? diff[tsbl_pkg::TS_W-1:0] : shifted[tsbl_pkg::TS_W-1:0];
            r_quot <= {r_quot[tsbl_pkg::FRAC_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/timestamp_bracket_lookup_core.sv -----
// Top level: sorted timestamp table with lower/upper bound lookup and fraction.
//
//  channel  | dir | tdata                          | tuser
//  ---------+-----+--------------------------------+-------------
//  s_axis   | in  | time_stamp[63:0]               | kind[1:0]
//  m_axis   | out | lower, upper, fraction, pad    | status[3:0]
//
// One item at a time; input is ready only when idle. Kind 3 is dropped with no result;
// clear and a query on an empty table go straight to the result, append checks first.
// Query: a start state, bound search steps (one table read each), resolve and result;
// interpolating adds 2 table reads and a divider run before the result is given.
// Reset clears state, entry count and output valid; unwritten table words go unused.
// A held result does not block input; a stalled m_axis holds the next result.
module timestamp_bracket_lookup_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,  // time_stamp[63:0]
    input  logic [1:0]                          s_axis_tuser,  // kind[1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // lower_index[9:0], upper_index[20:10], fraction[36:21], zero[39:37]
    output logic [tsbl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [3:0]                          m_axis_tuser   // status[3:0]
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_CHK,
        S_QSTART,
        S_SEARCH,
        S_RESOLVE,
        S_INT_RDHI,
        S_INT_CAP,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state;
    tsbl_pkg::t_ts     r_ts;
    tsbl_pkg::t_cnt    r_count;
    tsbl_pkg::t_cnt    r_lo;
    tsbl_pkg::t_cnt    r_hi;
    tsbl_pkg::t_idx    r_mid;
    logic              r_strict;
    tsbl_pkg::t_cnt    r_lb;
    tsbl_pkg::t_cnt    r_ub;
    tsbl_pkg::t_ts     r_lo_t;

    tsbl_pkg::t_status r_res_status;
    logic [tsbl_pkg::LOWER_W-1:0] r_res_lower;
    logic [tsbl_pkg::UPPER_W-1:0] r_res_upper;
    tsbl_pkg::t_frac   r_res_frac;

    logic              r_out_valid;
    tsbl_pkg::t_status r_out_status;
    logic [tsbl_pkg::LOWER_W-1:0] r_out_lower;
    logic [tsbl_pkg::UPPER_W-1:0] r_out_upper;
    tsbl_pkg::t_frac   r_out_frac;

    tsbl_pkg::t_ts      rd_data;
    tsbl_pkg::t_idx     rd_addr;
    logic               wr_en;
    tsbl_pkg::t_div_req div_req;
    logic               div_done;
    tsbl_pkg::t_frac    div_quot;

    logic              accept;
    logic              go_right;
    tsbl_pkg::t_cnt    step_lo;
    tsbl_pkg::t_cnt    step_hi;
    logic              step_more;
    logic              ub_more;
    tsbl_pkg::t_idx    step_mid;
    logic              order_bad;
    tsbl_pkg::t_cnt    count_m1;
    tsbl_pkg::t_cnt    lb_m1;

    function automatic tsbl_pkg::t_idx mid_of(input tsbl_pkg::t_cnt lo,
                                              input tsbl_pkg::t_cnt hi);
        tsbl_pkg::t_cnt s;
        s = lo + ((hi - lo) >> 1);
        return s[tsbl_pkg::IDX_W-1:0];
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign count_m1      = r_count - 1'b1;
    assign lb_m1         = r_lb - 1'b1;

    // one bisection step on the word read for r_mid
    always_comb begin
        go_right  = r_strict ? (rd_data <= r_ts) : (rd_data < r_ts);
        step_lo   = go_right ? ({1'b0, r_mid} + 1'b1) : r_lo;
        step_hi   = go_right ? r_hi : {1'b0, r_mid};
        step_more = (step_lo < step_hi);
        ub_more   = (step_lo < r_count);
        step_mid  = step_more ? mid_of(step_lo, step_hi) : mid_of(step_lo, r_count);
        order_bad = (r_count != '0) && (r_ts < rd_data);
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:     rd_addr = count_m1[tsbl_pkg::IDX_W-1:0];
            S_SEARCH:   rd_addr = step_mid;
            S_RESOLVE:  rd_addr = lb_m1[tsbl_pkg::IDX_W-1:0];
            S_INT_RDHI: rd_addr = r_lb[tsbl_pkg::IDX_W-1:0];
            default:    rd_addr = r_mid;
        endcase
    end

    assign wr_en = (r_state == S_APP_CHK) && (r_count != tsbl_pkg::DEPTH_CNT) && !order_bad;

    assign div_req.start = (r_state == S_INT_CAP);
    assign div_req.num   = r_ts - r_lo_t;
    assign div_req.den   = rd_data - r_lo_t;

    tsbl_ram #(
        .ADDR_W (tsbl_pkg::IDX_W),
        .DATA_W (tsbl_pkg::TS_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[tsbl_pkg::IDX_W-1:0]),
        .i_wr_data (r_ts),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tsbl_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result beat replaces the one draining this cycle
            if (r_state == S_EMIT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ts         <= s_axis_tdata;
                        r_res_status <= tsbl_pkg::STS_OK;
                        r_res_lower  <= '0;
                        r_res_upper  <= '0;
                        r_res_frac   <= '0;
                        unique case (s_axis_tuser)
                            tsbl_pkg::KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_EMIT;
                            end
                            tsbl_pkg::KIND_APPEND: begin
                                r_state <= S_APP_CHK;
                            end
                            tsbl_pkg::KIND_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_status <= tsbl_pkg::STS_EMPTY;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_lo     <= '0;
                                    r_hi     <= r_count;
                                    r_mid    <= mid_of('0, r_count);
                                    r_strict <= 1'b0;
                                    r_state  <= S_QSTART;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_APP_CHK: begin
                    if (r_count == tsbl_pkg::DEPTH_CNT) begin
                        r_res_status <= tsbl_pkg::STS_FULL;
                    end else if (order_bad) begin
                        r_res_status <= tsbl_pkg::STS_ORDER;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_QSTART: begin
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    r_mid <= step_mid;
                    if (step_more) begin
                        r_lo <= step_lo;
                        r_hi <= step_hi;
                    end else if (!r_strict) begin
                        // lower bound found; upper bound search starts from it
                        r_lb <= step_lo;
                        if (ub_more) begin
                            r_lo     <= step_lo;
                            r_hi     <= r_count;
                            r_strict <= 1'b1;
                        end else begin
                            r_ub    <= r_count;
                            r_state <= S_RESOLVE;
                        end
                    end else begin
                        r_ub    <= step_lo;
                        r_state <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    r_state <= S_EMIT;
                    priority if (r_ub == r_lb + 1'b1) begin
                        r_res_status <= tsbl_pkg::STS_SINGLE;
                        r_res_lower  <= r_lb[tsbl_pkg::LOWER_W-1:0];
                        r_res_upper  <= r_ub;
                    end else if (r_ub != r_lb) begin
                        r_res_status <= tsbl_pkg::STS_MULTIPLE;
                        r_res_lower  <= r_lb[tsbl_pkg::LOWER_W-1:0];
                        r_res_upper  <= r_ub;
                    end else if (r_lb == '0) begin
                        r_res_status <= tsbl_pkg::STS_BEFORE;
                    end else if (r_lb == r_count) begin
                        r_res_status <= tsbl_pkg::STS_AFTER;
                        r_res_lower  <= count_m1[tsbl_pkg::LOWER_W-1:0];
                        r_res_upper  <= r_count;
                    end else begin
                        r_res_status <= tsbl_pkg::STS_INTERP;
                        r_res_lower  <= lb_m1[tsbl_pkg::LOWER_W-1:0];
                        r_res_upper  <= r_lb;
                        r_state      <= S_INT_RDHI;
                    end
                end
                S_INT_RDHI: begin
                    r_lo_t  <= rd_data;
                    r_state <= S_INT_CAP;
                end
                S_INT_CAP: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_res_frac <= div_quot;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_status <= r_res_status;
                        r_out_lower  <= r_res_lower;
                        r_out_upper  <= r_res_upper;
                        r_out_frac   <= r_res_frac;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(tsbl_pkg::OUT_DATA_W - tsbl_pkg::LOWER_W - tsbl_pkg::UPPER_W
                             - tsbl_pkg::FRAC_W){1'b0}},
                            r_out_frac, r_out_upper, r_out_lower};

endmodule

// ----- design/tsbl_checker.sv -----
// Port-level checks for the timestamp bracket lookup core, bound to the top level.
module tsbl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tsbl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [3:0]                      m_axis_tuser
);

    logic [9:0]  lower;
    logic [10:0] upper;
    logic [15:0] frac;

    assign lower = m_axis_tdata[9:0];
    assign upper = m_axis_tdata[20:10];
    assign frac  = m_axis_tdata[36:21];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // an accepted meaningful beat closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == tsbl_pkg::KIND_CLEAR || s_axis_tuser == tsbl_pkg::KIND_APPEND ||
             s_axis_tuser == tsbl_pkg::KIND_QUERY) |=> !s_axis_tready)
        else $error("input ready right after accepting a beat");

    a_bracket_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tsbl_pkg::STS_SINGLE ||
                          m_axis_tuser == tsbl_pkg::STS_INTERP) |->
            upper == {1'b0, lower} + 11'd1)
        else $error("bracket indices not adjacent");

    a_frac_only_interp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != tsbl_pkg::STS_INTERP |-> frac == '0)
        else $error("nonzero fraction outside interpolation");

    a_zero_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tsbl_pkg::STS_OK || m_axis_tuser == tsbl_pkg::STS_FULL ||
                          m_axis_tuser == tsbl_pkg::STS_ORDER ||
                          m_axis_tuser == tsbl_pkg::STS_EMPTY ||
                          m_axis_tuser == tsbl_pkg::STS_BEFORE) |->
            lower == '0 && upper == '0)
        else $error("indices set on a status that carries none");

endmodule

bind timestamp_bracket_lookup_core tsbl_checker u_tsbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
